FILE: hdl/jpr_pkg.sv
`timescale 1ns / 1ps

package jpr_pkg;

    // Field widths
    localparam int unsigned OFS_W    = 2;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned FIRE_W   = 5;
    localparam int unsigned ROW_W    = 2;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // Byte offsets within the port
    localparam logic [OFS_W-1:0] OFS_WORD0  = 2'd0;
    localparam logic [OFS_W-1:0] OFS_SELECT = 2'd1;
    localparam logic [OFS_W-1:0] OFS_WORD2  = 2'd2;

    // Configuration register byte addresses
    localparam logic [APB_AW-1:0] REG_NTSC_ADDR = 3'd0;

    // Read constants
    localparam logic [WORD_W-1:0] IDLE_WORD    = 16'hFFFF;
    localparam logic [WORD_W-1:0] WORD2_BASE   = 16'hFF6F;
    localparam int unsigned       NTSC_BIT     = 4;
    localparam int unsigned       EN_BIT       = 15;
    localparam int unsigned       P0_FIRE_BIT  = 1;
    localparam int unsigned       P0_PAUSE_BIT = 0;
    localparam int unsigned       P1_FIRE_BIT  = 3;
    localparam int unsigned       P1_PAUSE_BIT = 2;
    localparam int unsigned       PAUSE_IDX    = 4;

    // Row selection decoded from one select nibble
    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } row_sel_t;

    // Pipeline state seen by the read logic
    typedef struct packed {
        logic       enabled;
        logic [7:0] select;
        logic       ntsc;
    } port_state_t;

    function automatic row_sel_t pad0_row(input logic [3:0] nib);
        row_sel_t r;
        r.hit = 1'b1;
        case (nib)
            4'h7:    r.row = 2'd3;
            4'hB:    r.row = 2'd2;
            4'hD:    r.row = 2'd1;
            4'hE:    r.row = 2'd0;
            default:
            begin
                r.hit = 1'b0;
                r.row = 2'd0;
            end
        endcase
        return r;
    endfunction

    function automatic row_sel_t pad1_row(input logic [3:0] nib);
        row_sel_t r;
        r.hit = 1'b1;
        case (nib)
            4'h7:    r.row = 2'd0;
            4'hB:    r.row = 2'd1;
            4'hD:    r.row = 2'd2;
            4'hE:    r.row = 2'd3;
            default:
            begin
                r.hit = 1'b0;
                r.row = 2'd0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/jpr_read_logic.sv
`timescale 1ns / 1ps

// Read value for one access: row decode of the select byte, then masking.
module jpr_read_logic
(
    input  jpr_pkg::port_state_t          state,
    input  logic [jpr_pkg::OFS_W-1:0]     word_offset,
    input  logic [jpr_pkg::WORD_W-1:0]    pad0_matrix,
    input  logic [jpr_pkg::FIRE_W-1:0]    pad0_fire,
    input  logic [jpr_pkg::WORD_W-1:0]    pad1_matrix,
    input  logic [jpr_pkg::FIRE_W-1:0]    pad1_fire,
    output logic [jpr_pkg::WORD_W-1:0]    read_data
);

    jpr_pkg::row_sel_t          r0;
    jpr_pkg::row_sel_t          r1;
    logic [3:0]                 cols0;
    logic [3:0]                 cols1;
    logic [jpr_pkg::WORD_W-1:0] word0;
    logic [jpr_pkg::WORD_W-1:0] word2;

    assign r0    = jpr_pkg::pad0_row(state.select[3:0]);
    assign r1    = jpr_pkg::pad1_row(state.select[7:4]);
    assign cols0 = pad0_matrix[{r0.row, 2'b00} +: 4];
    assign cols1 = pad1_matrix[{r1.row, 2'b00} +: 4];

    always_comb
    begin
        word0 = jpr_pkg::IDLE_WORD;
        if (state.enabled)
        begin
            if (r0.hit)
            begin
                word0[11:8] = ~cols0;
                // row 0 carries no tag bit
                if (r0.row != 2'd0)
                    word0[{2'b00, r0.row}] = 1'b0;
            end
            if (r1.hit)
            begin
                word0[15:12]                   = ~cols1;
                word0[4'd7 - {2'b00, r1.row}]  = 1'b0;
            end
        end
    end

    always_comb
    begin
        word2 = jpr_pkg::WORD2_BASE;
        word2[jpr_pkg::NTSC_BIT] = state.ntsc;
        if (state.enabled)
        begin
            if (r0.hit)
            begin
                if (pad0_fire[{1'b0, r0.row}])
                    word2[jpr_pkg::P0_FIRE_BIT] = 1'b0;
                if (r0.row == 2'd0 && pad0_fire[jpr_pkg::PAUSE_IDX])
                    word2[jpr_pkg::P0_PAUSE_BIT] = 1'b0;
            end
            if (r1.hit)
            begin
                if (pad1_fire[{1'b0, r1.row}])
                    word2[jpr_pkg::P1_FIRE_BIT] = 1'b0;
                if (r1.row == 2'd0 && pad1_fire[jpr_pkg::PAUSE_IDX])
                    word2[jpr_pkg::P1_PAUSE_BIT] = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (word_offset)
            jpr_pkg::OFS_WORD0: read_data = word0;
            jpr_pkg::OFS_WORD2: read_data = word2;
            default:            read_data = jpr_pkg::IDLE_WORD;
        endcase
    end

endmodule

FILE: hdl/joypad_port_registers_core.sv
`timescale 1ns / 1ps

// A read transaction's result passes through the input register, then the
// result register; a write yields no result.
// Throughput: one transaction per cycle, stalled only while a read waits in
// the input register, the result register is full and out_ready is low.
// Reset (rst_n, async, active low): pads disabled, select byte zero,
// ntsc_mode one, both pipeline stages empty.
module joypad_port_registers_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [jpr_pkg::OFS_W-1:0]     word_offset,
    input  logic [jpr_pkg::WORD_W-1:0]    write_value,
    input  logic [jpr_pkg::WORD_W-1:0]    pad0_matrix,
    input  logic [jpr_pkg::FIRE_W-1:0]    pad0_fire,
    input  logic [jpr_pkg::WORD_W-1:0]    pad1_matrix,
    input  logic [jpr_pkg::FIRE_W-1:0]    pad1_fire,

    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [jpr_pkg::WORD_W-1:0]    read_data,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jpr_pkg::APB_AW-1:0]    paddr,
    input  logic [jpr_pkg::APB_DW-1:0]    pwdata,
    output logic [jpr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // ---------------------------------------------------------------
    // Input register: one accepted transaction waiting to be processed
    // ---------------------------------------------------------------
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    jpr_pkg::cmd_t                 s1_cmd_reg;
    logic [jpr_pkg::OFS_W-1:0]     s1_ofs_reg;
    logic [jpr_pkg::WORD_W-1:0]    s1_wdata_reg;
    logic [jpr_pkg::WORD_W-1:0]    s1_m0_reg;
    logic [jpr_pkg::FIRE_W-1:0]    s1_f0_reg;
    logic [jpr_pkg::WORD_W-1:0]    s1_m1_reg;
    logic [jpr_pkg::FIRE_W-1:0]    s1_f1_reg;

    // Port state. Only the select byte and the enable flag are ever
    // observable, so the other stored bytes are not kept.
    logic                          enabled_reg;
    logic                          enabled_next;
    logic [7:0]                    select_reg;
    logic [7:0]                    select_next;
    logic                          ntsc_reg;
    logic                          ntsc_next;

    // Result register
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [jpr_pkg::WORD_W-1:0]    res_data_reg;
    logic [jpr_pkg::WORD_W-1:0]    res_data_next;

    logic                          in_fire;
    logic                          s1_fire;
    logic                          s1_is_write;
    logic                          cfg_write;
    logic [jpr_pkg::WORD_W-1:0]    rd_value;
    jpr_pkg::port_state_t          state;

    // A write leaves the stage without needing the result slot; a read
    // needs the slot empty or draining this cycle.
    assign s1_is_write = (s1_cmd_reg == jpr_pkg::CMD_WRITE);
    assign s1_fire     = s1_valid_reg
                       && (s1_is_write || !res_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || s1_fire;
    assign in_fire     = in_valid && in_ready;

    assign state.enabled = enabled_reg;
    assign state.select  = select_reg;
    assign state.ntsc    = ntsc_reg;

    jpr_read_logic u_read
    (
        .state       (state),
        .word_offset (s1_ofs_reg),
        .pad0_matrix (s1_m0_reg),
        .pad0_fire   (s1_f0_reg),
        .pad1_matrix (s1_m1_reg),
        .pad1_fire   (s1_f1_reg),
        .read_data   (rd_value)
    );

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        enabled_next = enabled_reg;
        select_next  = select_reg;
        if (s1_fire && s1_is_write)
        begin
            // high byte lands at the offset, low byte at offset + 1
            if (s1_ofs_reg == jpr_pkg::OFS_WORD0)
            begin
                select_next  = s1_wdata_reg[7:0];
                enabled_next = s1_wdata_reg[jpr_pkg::EN_BIT];
            end
            else if (s1_ofs_reg == jpr_pkg::OFS_SELECT)
            begin
                select_next = s1_wdata_reg[15:8];
            end
        end
    end

    always_comb
    begin
        ntsc_next = ntsc_reg;
        if (cfg_write && paddr[jpr_pkg::APB_AW-1] == 1'b0)
            ntsc_next = pwdata[0];
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (s1_fire && !s1_is_write)
        begin
            res_valid_next = 1'b1;
            res_data_next  = rd_value;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            select_reg    <= 8'h00;
            ntsc_reg      <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            enabled_reg   <= enabled_next;
            select_reg    <= select_next;
            ntsc_reg      <= ntsc_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= jpr_pkg::cmd_t'(command);
            s1_ofs_reg   <= word_offset;
            s1_wdata_reg <= write_value;
            s1_m0_reg    <= pad0_matrix;
            s1_f0_reg    <= pad0_fire;
            s1_m1_reg    <= pad1_matrix;
            s1_f1_reg    <= pad1_fire;
        end
        res_data_reg <= res_data_next;
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign out_valid = res_valid_reg;
    assign read_data = res_data_reg;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == jpr_pkg::REG_NTSC_ADDR)
            prdata[0] = ntsc_reg;
    end

endmodule

FILE: hdl/jpr_checker.sv
`timescale 1ns / 1ps

module jpr_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [jpr_pkg::WORD_W-1:0]    read_data
);

    // Backpressure on the request side only comes from a full result slot.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low while no result is pending");

    // A new result comes from a read transaction passed through the input register, then the result register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request transaction");

    // Only a word 2 read can clear bit 0, and then its fixed bits hold.
    a_word2_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_data[0] |-> read_data[15:5] == 11'b11111111011)
        else $error("word 2 result has corrupted fixed bits");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result dropped or changed while stalled");

endmodule

bind joypad_port_registers_core jpr_checker u_jpr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
);
